/* rtl/dbin_pkg.sv */
// shared types and constants for the depth pixel to voxel block binner
// no dependencies

package dbin_pkg;

  // sampling stride and its reciprocal for the stride test
  localparam int SAMPLE_STRIDE = 5;
  localparam int STRIDE_SH     = 26;
  localparam logic [26:0] STRIDE_RECIP =
    27'(((64'd1 << STRIDE_SH) + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE);

  // default dedupe table size
  localparam int TABLE_DEPTH = 64;

  // block grid offset and metre conversion
  localparam logic signed [35:0] GRID_OFFSET_MM = 36'sd3000;
  localparam logic signed [35:0] CORNER_MAX     = 36'sd32767999;
  localparam logic signed [35:0] CORNER_MIN     = -36'sd32768999;
  localparam int                 MM_SH          = 35;
  localparam logic [25:0]        MM_RECIP       = 26'd34359739;

  // magnitude width handled by the remainder unit
  localparam int DVD_W = 35;

  // register indexes
  localparam logic [3:0] CFG_XF_R0_AB  = 4'd0;
  localparam logic [3:0] CFG_XF_R0C_R1A = 4'd1;
  localparam logic [3:0] CFG_XF_R1_BC  = 4'd2;
  localparam logic [3:0] CFG_XF_R2_AB  = 4'd3;
  localparam logic [3:0] CFG_XF_R2C_TX = 4'd4;
  localparam logic [3:0] CFG_XF_TY_TZ  = 4'd5;
  localparam logic [3:0] CFG_BLOCK_SIZE = 4'd6;
  localparam logic [3:0] CFG_MAX_DEPTH = 4'd7;

  typedef logic [47:0] key_t;

  typedef struct packed {
    logic        frame_start;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [15:0] depth_mm;
  } in_t;

  typedef struct packed {
    logic signed [15:0] block_x_m;
    logic signed [15:0] block_y_m;
    logic signed [15:0] block_z_m;
    logic               table_full;
  } out_t;

  // lookup request travelling down the table
  typedef struct packed {
    logic vld;
    logic hit;
    key_t key;
  } probe_t;

endpackage

/* rtl/depth_pixel_to_voxel_block_binner.sv */
// top level of the depth pixel to voxel block binner
// depends on dbin_pkg, dbin_rem and dbin_cell
//
// Usage: depth pixels arrive on in_valid / in_stall / in_data, one request
// at a time; in_stall is high while a pixel is being worked on. Block keys
// leave on out_valid / out_stall / out_data from an output register, so the
// next pixel is taken while a key still waits there. Configuration writes
// go over cfg_valid / cfg_ready / cfg_index / cfg_data; the user must make
// them only while idle, since the block itself does not enforce it. A
// rejected pixel (off stride, no depth, too deep) goes back to idle from
// the check state. A kept pixel runs its three axes one after another
// through one projection path and the bit serial remainder unit, then its
// key walks the table cell chain. frame_start empties the table at once by
// zeroing its fill count. Reset clears the table and loads register
// defaults. While out_stall holds, a finished key waits in its state until
// the output register frees.

module depth_pixel_to_voxel_block_binner #(
  parameter int TABLE_DEPTH = dbin_pkg::TABLE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dbin_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dbin_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      cfg_index,
  input  logic [63:0]     cfg_data
);
  import dbin_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK, ST_MUL, ST_SUM, ST_MUL2, ST_PROJ, ST_DSTART,
    ST_DIV, ST_FIX, ST_SCALE, ST_PROBE, ST_WAIT, ST_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [63:0] xf_r [6];
  logic [15:0] bs_r, maxd_r;
  logic [15:0] bs_eff;

  assign cfg_ready = 1'b1;
  assign bs_eff    = (bs_r == '0) ? 16'd1 : bs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) xf_r[i] <= '0;
      bs_r   <= 16'd2000;
      maxd_r <= 16'd10000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_XF_R0_AB:   xf_r[0] <= cfg_data;
        CFG_XF_R0C_R1A: xf_r[1] <= cfg_data;
        CFG_XF_R1_BC:   xf_r[2] <= cfg_data;
        CFG_XF_R2_AB:   xf_r[3] <= cfg_data;
        CFG_XF_R2C_TX:  xf_r[4] <= cfg_data;
        CFG_XF_TY_TZ:   xf_r[5] <= cfg_data;
        CFG_BLOCK_SIZE: bs_r    <= cfg_data[15:0];
        CFG_MAX_DEPTH:  maxd_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic [11:0] col_r, row_r, qc_r, qr_r;
  logic [15:0] dep_r;
  logic [1:0]  axis_r;
  logic signed [44:0] p0_r, p1_r;
  logic signed [45:0] s_r;
  logic [38:0]        lo_r;
  logic signed [39:0] hi_r;
  logic signed [35:0] p_r;
  logic               xneg_r;
  logic [DVD_W-1:0]   xmag_r;
  logic signed [25:0] c_r;
  logic [15:0]        m_r [3];
  logic [CW-1:0]      count_r;
  logic               full_r;
  out_t               res_r, out_r;
  logic               out_valid_r;

  // stride quotients of the incoming pixel
  logic [38:0] pc_col, pc_row;
  assign pc_col = {15'b0, in_data.pixel_col} * {12'b0, STRIDE_RECIP};
  assign pc_row = {15'b0, in_data.pixel_row} * {12'b0, STRIDE_RECIP};

  logic stride_ok, depth_ok;
  assign stride_ok = (({7'b0, qc_r} * 19'(SAMPLE_STRIDE)) == {7'b0, col_r}) &&
                     (({7'b0, qr_r} * 19'(SAMPLE_STRIDE)) == {7'b0, row_r});
  assign depth_ok  = (dep_r != '0) && (dep_r <= maxd_r);

  // per axis coefficients and translation
  logic signed [31:0] ca, cb, cc, tt;
  always_comb begin
    unique case (axis_r)
      2'd0: begin
        ca = xf_r[0][31:0];  cb = xf_r[0][63:32];
        cc = xf_r[1][31:0];  tt = xf_r[4][63:32];
      end
      2'd1: begin
        ca = xf_r[1][63:32]; cb = xf_r[2][31:0];
        cc = xf_r[2][63:32]; tt = xf_r[5][31:0];
      end
      default: begin
        ca = xf_r[3][31:0];  cb = xf_r[3][63:32];
        cc = xf_r[4][31:0];  tt = xf_r[5][63:32];
      end
    endcase
  end

  // projection datapath
  logic signed [44:0] p0_nxt, p1_nxt;
  logic signed [39:0] hi_nxt;
  logic [38:0]        lo_nxt;
  logic signed [63:0] v;
  logic signed [35:0] p_nxt, x_nxt;
  assign p0_nxt = ca * $signed({1'b0, col_r});
  assign p1_nxt = cb * $signed({1'b0, row_r});
  assign lo_nxt = {16'b0, s_r[22:0]} * {23'b0, dep_r};
  assign hi_nxt = $signed(s_r[45:23]) * $signed({1'b0, dep_r});
  assign v      = $signed({hi_r[39], hi_r, 23'b0}) + $signed({25'b0, lo_r});
  assign p_nxt  = $signed({{2{v[63]}}, v[63:30]}) + $signed({{4{tt[31]}}, tt});
  assign x_nxt  = p_nxt - GRID_OFFSET_MM;

  // floor remainder and corner
  logic        div_start, div_done;
  logic [15:0] div_rem, remf;
  logic signed [35:0] corner;
  assign div_start = (state_r == ST_DSTART);
  assign remf   = (xneg_r && (div_rem != '0)) ? (bs_eff - div_rem) : div_rem;
  assign corner = p_r - $signed({20'b0, remf});

  dbin_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (xmag_r),
    .divisor  (bs_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  // truncating metre conversion
  logic [24:0] cmag;
  logic [50:0] mprod;
  logic [16:0] mq, ms;
  assign cmag  = c_r[25] ? 25'(-c_r) : c_r[24:0];
  assign mprod = {26'b0, cmag} * {25'b0, MM_RECIP};
  assign mq    = {1'b0, mprod[50:35]};
  assign ms    = c_r[25] ? (17'd0 - mq) : mq;

  // table cell chain
  key_t   keys [TABLE_DEPTH+1];
  probe_t chain [TABLE_DEPTH+1];
  logic   shift_en;

  assign keys[0]      = {m_r[2], m_r[1], m_r[0]};
  assign chain[0].vld = (state_r == ST_PROBE);
  assign chain[0].hit = 1'b0;
  assign chain[0].key = keys[0];
  assign shift_en     = (state_r == ST_WAIT) && chain[TABLE_DEPTH].vld &&
                        !chain[TABLE_DEPTH].hit && (count_r != CW'(TABLE_DEPTH));

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    dbin_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (shift_en),
      .count     (count_r),
      .key_in    (keys[g]),
      .key_out   (keys[g+1]),
      .probe_in  (chain[g]),
      .probe_out (chain[g+1])
    );
  end

  assign in_stall = (state_r != ST_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            col_r  <= in_data.pixel_col;
            row_r  <= in_data.pixel_row;
            dep_r  <= in_data.depth_mm;
            qc_r   <= pc_col[37:26];
            qr_r   <= pc_row[37:26];
            axis_r <= 2'd0;
            if (in_data.frame_start) count_r <= '0;
            state_r <= ST_CHK;
          end
        end
        ST_CHK: state_r <= (stride_ok && depth_ok) ? ST_MUL : ST_IDLE;
        ST_MUL: begin
          p0_r    <= p0_nxt;
          p1_r    <= p1_nxt;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          s_r     <= 46'(p0_r) + 46'(p1_r) + 46'(cc);
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          lo_r    <= lo_nxt;
          hi_r    <= hi_nxt;
          state_r <= ST_PROJ;
        end
        ST_PROJ: begin
          p_r     <= p_nxt;
          xneg_r  <= x_nxt[35];
          xmag_r  <= x_nxt[35] ? DVD_W'(-x_nxt) : x_nxt[DVD_W-1:0];
          state_r <= ST_DSTART;
        end
        ST_DSTART: state_r <= ST_DIV;
        ST_DIV: if (div_done) state_r <= ST_FIX;
        ST_FIX: begin
          if (corner > CORNER_MAX)      c_r <= CORNER_MAX[25:0];
          else if (corner < CORNER_MIN) c_r <= CORNER_MIN[25:0];
          else                          c_r <= corner[25:0];
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          m_r[axis_r] <= ms[15:0];
          if (axis_r == 2'd2) begin
            state_r <= ST_PROBE;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= ST_MUL;
          end
        end
        ST_PROBE: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (chain[TABLE_DEPTH].vld) begin
            if (chain[TABLE_DEPTH].hit) begin
              state_r <= ST_IDLE;
            end else begin
              full_r  <= (count_r == CW'(TABLE_DEPTH));
              if (count_r != CW'(TABLE_DEPTH)) count_r <= count_r + 1'b1;
              state_r <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_r.block_x_m  <= m_r[0];
            out_r.block_y_m  <= m_r[1];
            out_r.block_z_m  <= m_r[2];
            out_r.table_full <= full_r;
            out_valid_r      <= 1'b1;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign res_r     = out_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule

/* rtl/dbin_cell.sv */
// one entry of the dedupe table: holds a key, checks the passing request
// depends on dbin_pkg

module dbin_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  logic [CW-1:0]   count,
  input  dbin_pkg::key_t  key_in,
  output dbin_pkg::key_t  key_out,
  input  dbin_pkg::probe_t probe_in,
  output dbin_pkg::probe_t probe_out
);
  import dbin_pkg::*;

  key_t   key_r;
  probe_t probe_r;
  logic   used;

  // entries below the fill count are live
  assign used = (count > CW'(IDX));

  // key shifts in from the neighbor on insert
  always_ff @(posedge clk) begin
    if (shift_en) begin
      key_r <= key_in;
    end
  end

  // request moves one cell per cycle, collecting a match
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else begin
      probe_r.vld <= probe_in.vld;
    end
    probe_r.hit <= probe_in.hit | (used && (key_r == probe_in.key));
    probe_r.key <= probe_in.key;
  end

  assign key_out   = key_r;
  assign probe_out = probe_r;

endmodule

/* rtl/dbin_rem.sv */
// iterative remainder unit, one quotient bit per cycle
// depends on dbin_pkg

module dbin_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dbin_pkg::DVD_W-1:0] dividend,
  input  logic [15:0]                divisor,
  output logic                       done,
  output logic [15:0]                rem
);
  import dbin_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [16:0]      rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [16:0]      trial;

  assign trial = {rem_r[15:0], dvd_r[DVD_W-1]};

  // restoring shift and subtract
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(DVD_W);
      done_r <= 1'b0;
      dvd_r  <= dividend;
      rem_r  <= '0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CNT_W'(1));
      dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_r <= trial - {1'b0, divisor};
      end else begin
        rem_r <= trial;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign rem  = rem_r[15:0];

endmodule
